// File: design/tpbd_pkg.sv
// Shared types, constants and window decode functions for the piece byte decoder.
`default_nettype none

package tpbd_pkg;

	localparam int WIN_DEPTH  = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_VOCAB_SIZE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOS_ID     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EOS_ID     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAD_ID     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_OUT    = 3'd4;

	localparam logic [7:0] SPM_B0   = 8'hE2;
	localparam logic [7:0] SPM_B1   = 8'h96;
	localparam logic [7:0] SPM_B2   = 8'h81;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X     = 8'h78;

	// Six-byte window, byte 0 is the head.
	typedef logic [WIN_DEPTH-1:0][7:0] win_t;

	// Classified input item as it sits in the queue.
	typedef struct packed {
		logic [7:0] data;
		logic       present;   // real byte of a live piece
		logic       last;
		logic       supp;      // id suppressed
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_head_t;

	// One greedy decision at the window head.
	typedef struct packed {
		win_t       win;
		logic [2:0] cnt;
		logic [7:0] data;
		logic       keep;
	} adv_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
		       (c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_nib(input logic [7:0] c);
		if (c <= 8'h39) begin
			return c[3:0];
		end
		return c[3:0] + 4'd9;
	endfunction

	function automatic adv_t win_advance(input win_t w, input logic [2:0] cnt);
		adv_t       r;
		logic       hex_form;
		logic       spc;
		logic [7:0] v;
		hex_form = (cnt == 3'(WIN_DEPTH)) && w[0] == CH_LT && w[1] == CH_ZERO &&
		           w[2] == CH_X && is_hex(w[3]) && is_hex(w[4]) && w[5] == CH_GT;
		spc      = (cnt >= 3'd3) && w[0] == SPM_B0 && w[1] == SPM_B1 && w[2] == SPM_B2;
		v        = {hex_nib(w[3]), hex_nib(w[4])};
		r.data   = w[0];
		r.keep   = 1'b1;
		r.win    = w >> 8;
		r.cnt    = cnt - 3'd1;
		if (hex_form) begin
			r.data = v;
			r.keep = (v >= CH_SPACE && v != CH_DEL) || v == CH_LF || v == CH_CR ||
			         v == CH_TAB;
			r.win  = '0;
			r.cnt  = 3'd0;
		end else if (spc) begin
			r.data = CH_SPACE;
			r.win  = w >> 24;
			r.cnt  = cnt - 3'd3;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: design/tpbd_in_if.sv
// Input channel: piece bytes with token id and piece framing.
`default_nettype none

interface tpbd_in_if;
	logic               valid;
	logic               ready;
	logic signed [19:0] token_id;
	logic        [7:0]  piece_byte;
	logic               byte_present;
	logic               last_byte;

	modport source (output valid, token_id, piece_byte, byte_present, last_byte,
	                input ready);
	modport sink   (input valid, token_id, piece_byte, byte_present, last_byte,
	                output ready);
endinterface

`default_nettype wire

// File: design/tpbd_out_if.sv
// Output channel: decoded text bytes and end markers.
`default_nettype none

interface tpbd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       text_valid;
	logic       end_of_piece;

	modport source (output valid, text_byte, text_valid, end_of_piece, input ready);
	modport sink   (input valid, text_byte, text_valid, end_of_piece, output ready);
endinterface

`default_nettype wire

// File: design/tpbd_front.sv
// Front end: configuration registers, id classification and queue push.
`default_nettype none

module tpbd_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [tpbd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tpbd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	tpbd_in_if.sink                                piece_in,
	input  wire logic                              q_full,
	output logic                                   push,
	output tpbd_pkg::q_entry_t                     push_entry,
	output logic [11:0]                            max_out
);

	logic        [18:0] vocab_size_q;
	logic        [18:0] bos_id_q;
	logic        [18:0] eos_id_q;
	logic signed [19:0] pad_id_q;
	logic        [11:0] max_out_q;
	logic               supp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vocab_size_q <= 19'd32000;
			bos_id_q     <= 19'd1;
			eos_id_q     <= 19'd2;
			pad_id_q     <= -20'sd1;
			max_out_q    <= 12'd255;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tpbd_pkg::CFG_VOCAB_SIZE: vocab_size_q <= cfg_wdata[18:0];
				tpbd_pkg::CFG_BOS_ID:     bos_id_q     <= cfg_wdata[18:0];
				tpbd_pkg::CFG_EOS_ID:     eos_id_q     <= cfg_wdata[18:0];
				tpbd_pkg::CFG_PAD_ID:     pad_id_q     <= cfg_wdata;
				tpbd_pkg::CFG_MAX_OUT:    max_out_q    <= cfg_wdata[11:0];
				default: ;
			endcase
		end
	end

	// Negative ids fail first, so the low 19 bits compare as unsigned.
	always_comb begin
		supp = piece_in.token_id[19] ||
		       (piece_in.token_id[18:0] >= vocab_size_q) ||
		       (piece_in.token_id[18:0] == bos_id_q) ||
		       (piece_in.token_id[18:0] == eos_id_q) ||
		       (piece_in.token_id == pad_id_q);
	end

	assign piece_in.ready     = !q_full;
	assign push               = piece_in.valid && !q_full;
	assign push_entry.data    = piece_in.piece_byte;
	assign push_entry.present = piece_in.byte_present && !supp;
	assign push_entry.last    = piece_in.last_byte;
	assign push_entry.supp    = supp;
	assign max_out            = max_out_q;

endmodule

`default_nettype wire

// File: design/tpbd_queue.sv
// Short queue of classified items between front and back.
`default_nettype none

module tpbd_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire tpbd_pkg::q_entry_t push_entry,
	input  wire logic               pop,
	output logic                    full,
	output tpbd_pkg::q_head_t       head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tpbd_pkg::q_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: design/tpbd_back.sv
// Back end: decode window, output limit, end-of-piece hold and output register.
`default_nettype none

module tpbd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tpbd_pkg::q_head_t head,
	input  wire logic [11:0]       max_out,
	output logic                   pop,
	tpbd_out_if.source             text_out
);

	tpbd_pkg::win_t win_q, win_d, win_a;
	logic [2:0]     cnt_q, cnt_d, cnt_a;
	logic [11:0]    emitted_q, emitted_d;
	logic           drain_q, drain_d;
	logic           hold_valid_q, hold_valid_d;
	logic [7:0]     hold_data_q, hold_data_d;
	logic           out_valid_q;
	logic [7:0]     out_byte_q;
	logic           out_tv_q;
	logic           out_eop_q;
	logic           can_push;
	logic           push;
	logic [7:0]     push_byte;
	logic           push_tv;
	logic           push_eop;
	tpbd_pkg::adv_t adv;
	logic           emit;

	assign can_push = !out_valid_q || text_out.ready;

	always_comb begin
		win_d        = win_q;
		cnt_d        = cnt_q;
		emitted_d    = emitted_q;
		drain_d      = drain_q;
		hold_valid_d = hold_valid_q;
		hold_data_d  = hold_data_q;
		pop          = 1'b0;
		push         = 1'b0;
		push_byte    = '0;
		push_tv      = 1'b0;
		push_eop     = 1'b0;
		win_a        = win_q;
		cnt_a        = cnt_q;
		adv          = tpbd_pkg::win_advance(win_q, cnt_q);
		emit         = 1'b0;

		if (!drain_q) begin
			pop = head.valid && can_push;
			if (head.entry.present && cnt_q < 3'(tpbd_pkg::WIN_DEPTH)) begin
				win_a[cnt_q] = head.entry.data;
				cnt_a        = cnt_q + 3'd1;
			end
			adv  = tpbd_pkg::win_advance(win_a, cnt_a);
			emit = adv.keep && (emitted_q < max_out);
			if (pop) begin
				priority if (head.entry.last && head.entry.supp) begin
					// drop the window, only the end marker follows
					cnt_d   = '0;
					drain_d = 1'b1;
				end else if (head.entry.last) begin
					win_d   = win_a;
					cnt_d   = cnt_a;
					drain_d = 1'b1;
				end else if (cnt_a == 3'(tpbd_pkg::WIN_DEPTH)) begin
					win_d = adv.win;
					cnt_d = adv.cnt;
					if (emit) begin
						emitted_d = emitted_q + 12'd1;
						push      = 1'b1;
						push_byte = adv.data;
						push_tv   = 1'b1;
					end
				end else begin
					win_d = win_a;
					cnt_d = cnt_a;
				end
			end
		end else if (can_push) begin
			emit = adv.keep && (emitted_q < max_out);
			if (cnt_q != '0) begin
				win_d = adv.win;
				cnt_d = adv.cnt;
				if (emit) begin
					emitted_d   = emitted_q + 12'd1;
					// release the previous byte, hold this one for the end mark
					push        = hold_valid_q;
					push_byte   = hold_data_q;
					push_tv     = 1'b1;
					hold_valid_d = 1'b1;
					hold_data_d  = adv.data;
				end
			end else begin
				push         = 1'b1;
				push_byte    = hold_valid_q ? hold_data_q : 8'h00;
				push_tv      = hold_valid_q;
				push_eop     = 1'b1;
				hold_valid_d = 1'b0;
				emitted_d    = '0;
				drain_d      = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		win_q       <= win_d;
		hold_data_q <= hold_data_d;
		if (push) begin
			out_byte_q <= push_byte;
			out_tv_q   <= push_tv;
			out_eop_q  <= push_eop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			emitted_q    <= '0;
			drain_q      <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			cnt_q        <= cnt_d;
			emitted_q    <= emitted_d;
			drain_q      <= drain_d;
			hold_valid_q <= hold_valid_d;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (text_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign text_out.valid        = out_valid_q;
	assign text_out.text_byte    = out_byte_q;
	assign text_out.text_valid   = out_tv_q;
	assign text_out.end_of_piece = out_eop_q;

endmodule

`default_nettype wire

// File: design/token_piece_byte_decoder.sv
// Top level of the piece byte decoder: front, item queue and back.
//
//  channel    dir  handshake       payload
//  piece_in   in   valid/ready     token_id, piece_byte, byte_present, last_byte
//  text_out   out  valid/ready     text_byte, text_valid, end_of_piece
//  cfg        in   cfg_we only     cfg_index, cfg_wdata
//
// For a non-last item the back end appends its byte to the six-byte window and,
// once the window is full, makes one greedy decision with at most one result.
// For a last item it first takes the byte into the window, then takes one step
// per greedy decision the window still holds, d (0..6) of them (a suppressed
// piece has none), and last sends the end-marked result.
// Reset clears all control state; the window needs none. The queue decouples
// input from output stalls; the back end steps only when the output register is
// free or being emptied in the same cycle.
`default_nettype none

module token_piece_byte_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [tpbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tpbd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	tpbd_in_if.sink                              piece_in,
	tpbd_out_if.source                           text_out
);

	// front to queue
	logic               push;
	tpbd_pkg::q_entry_t push_entry;
	logic               q_full;
	// queue to back
	tpbd_pkg::q_head_t  head;
	logic               pop;
	logic [11:0]        max_out;

	// Classify each item at the door; only the suppress flag, not the id, reaches the back end.
	tpbd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.piece_in   (piece_in),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry),
		.max_out    (max_out)
	);

	tpbd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.head       (head)
	);

	// Window, limit counter and the held byte that takes the end-of-piece mark.
	tpbd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.max_out  (max_out),
		.pop      (pop),
		.text_out (text_out)
	);

endmodule

`default_nettype wire

// File: design/tpbd_checker.sv
// Port-level checks on the decoder output, bound to the top level.
`default_nettype none

module tpbd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] text_byte,
	input wire logic       text_valid,
	input wire logic       end_of_piece
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid during reset");

	a_marker_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !text_valid |-> end_of_piece && text_byte == 8'h00)
		else $error("bare end marker malformed");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output item dropped while stalled");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		$stable(text_byte) && $stable(text_valid) && $stable(end_of_piece))
		else $error("output item changed while stalled");

endmodule

bind token_piece_byte_decoder tpbd_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (text_out.valid),
	.out_ready    (text_out.ready),
	.text_byte    (text_out.text_byte),
	.text_valid   (text_out.text_valid),
	.end_of_piece (text_out.end_of_piece)
);

`default_nettype wire
